>>> hw/rtl/lacr_pkg.sv
package lacr_pkg;

  localparam int CHANNELS     = 4;
  localparam int COUNT_INPUTS = 4;
  localparam int FIXED_MASKS  = 4;
  localparam int ADDR_W       = 64;
  localparam int CNT_W        = 8;
  localparam int CH_W         = 2;
  localparam int SHIFT_W      = 6;
  localparam int SW_W         = 3;
  localparam int REG_IDX_W    = 3;

  // Channels in use never exceed the channel count nor the count inputs.
  localparam int CHAN_LIMIT   = (CHANNELS < COUNT_INPUTS) ? CHANNELS : COUNT_INPUTS;
  localparam int MAX_ACT_BITS = $clog2(CHAN_LIMIT + 1) - 1;

  typedef logic [ADDR_W-1:0]  addr_t;
  typedef logic [CNT_W-1:0]   cnt_t;
  typedef logic [CH_W-1:0]    ch_t;
  typedef logic [SHIFT_W-1:0] shift_t;

  localparam addr_t FIXED_MASK [FIXED_MASKS] = '{
    64'h0000_0000_0000_0800,
    64'h0000_0000_0000_1000,
    64'h0000_0000_0000_2000,
    64'h0000_0000_0000_4000
  };

  typedef enum logic [1:0] {
    MODE_BASE   = 2'd0,
    MODE_SINGLE = 2'd1,
    MODE_SEARCH = 2'd2
  } mode_t;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_MODE       = 3'd0,
    REG_XOR_MASK   = 3'd1,
    REG_THRESHOLD  = 3'd2,
    REG_SEARCH_W   = 3'd3,
    REG_MARGIN     = 3'd4,
    REG_ADDR_SHIFT = 3'd5,
    REG_CH_POS     = 3'd6,
    REG_CH_BITS    = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [1:0]      mode;
    addr_t           xor_mask;
    cnt_t            threshold;
    logic [SW_W-1:0] search_width;
    cnt_t            margin;
    shift_t          addr_shift;
    shift_t          ch_pos;
    logic [1:0]      ch_bits;
  } cfg_t;

  typedef struct packed {
    addr_t                         addr;
    cnt_t [COUNT_INPUTS-1:0]       count;
  } req_t;

  typedef struct packed {
    ch_t   ch;
    addr_t addr;
    logic  remapped;
  } res_t;

endpackage

>>> hw/rtl/lacr_core.sv
module lacr_core
  import lacr_pkg::*;
(
  input  cfg_t cfg,
  input  req_t req,
  output res_t res
);

  // Channel field of an address; pos may run past the top, giving zeros.
  function automatic ch_t chan_of(addr_t a, logic [SHIFT_W:0] pos, logic [1:0] bits);
    logic [2*ADDR_W-1:0] ext;
    ch_t                 msk;
    ext = {{ADDR_W{1'b0}}, a} >> pos;
    msk = CH_W'((3'b001 << bits) - 3'b001);
    return ext[CH_W-1:0] & msk;
  endfunction

  logic [SHIFT_W:0] pos;
  logic [1:0]       act_bits;
  ch_t              base;
  cnt_t             mn2, mx2, mn_lo, mx_lo, mn_hi, mx_hi, mn, mx, spread;
  logic             enable;
  ch_t              alt_ch;
  ch_t              cand_ch;
  ch_t              best_ch;
  addr_t            sel_addr;
  cnt_t             best_q;
  logic [SW_W-1:0]  k;
  ch_t              mask_ch [FIXED_MASKS];

  assign pos = {1'b0, cfg.addr_shift} + {1'b0, cfg.ch_pos};

  always_comb begin
    if (cfg.ch_bits > 2'(MAX_ACT_BITS)) begin
      act_bits = 2'(MAX_ACT_BITS);
    end else begin
      act_bits = cfg.ch_bits;
    end

    base = chan_of(req.addr, pos, act_bits);

    // Spread over the active channels only.
    mn_lo = (req.count[0] < req.count[1]) ? req.count[0] : req.count[1];
    mx_lo = (req.count[0] > req.count[1]) ? req.count[0] : req.count[1];
    mn_hi = (req.count[2] < req.count[3]) ? req.count[2] : req.count[3];
    mx_hi = (req.count[2] > req.count[3]) ? req.count[2] : req.count[3];
    mn2   = (mn_lo < mn_hi) ? mn_lo : mn_hi;
    mx2   = (mx_lo > mx_hi) ? mx_lo : mx_hi;
    if (act_bits == 2'd1) begin
      mn = mn_lo;
      mx = mx_lo;
    end else begin
      mn = mn2;
      mx = mx2;
    end
    spread = mx - mn;

    enable = ((cfg.mode == MODE_SINGLE) || (cfg.mode == MODE_SEARCH)) &&
             (act_bits != 2'd0) && (cfg.xor_mask != '0) &&
             (spread >= cfg.threshold);

    if (cfg.search_width == '0) begin
      k = SW_W'(1);
    end else if (cfg.search_width > SW_W'(FIXED_MASKS)) begin
      k = SW_W'(FIXED_MASKS);
    end else begin
      k = cfg.search_width;
    end

    // The channel field is linear in the address, so a masked address maps
    // to the base channel xor the mask's own field.
    alt_ch = base ^ chan_of(cfg.xor_mask, pos, act_bits);
    for (int i = 0; i < FIXED_MASKS; i++) begin
      mask_ch[i] = chan_of(FIXED_MASK[i], pos, act_bits);
    end

    best_ch  = base;
    sel_addr = req.addr;
    best_q   = req.count[base];
    cand_ch  = base;

    if (enable && (cfg.mode == MODE_SINGLE)) begin
      if ((alt_ch != base) &&
          ({1'b0, req.count[alt_ch]} + 9'd1 < {1'b0, req.count[base]})) begin
        best_ch  = alt_ch;
        sel_addr = req.addr ^ cfg.xor_mask;
      end
    end else if (enable && (cfg.mode == MODE_SEARCH)) begin
      for (int i = 0; i < FIXED_MASKS; i++) begin
        cand_ch = base ^ mask_ch[i];
        if ((SW_W'(i) < k) && (cand_ch != base) &&
            ({1'b0, req.count[cand_ch]} + {1'b0, cfg.margin} < {1'b0, best_q})) begin
          best_q   = req.count[cand_ch];
          best_ch  = cand_ch;
          sel_addr = req.addr ^ FIXED_MASK[i];
        end
      end
    end

    res.ch       = best_ch;
    res.addr     = (best_ch == base) ? req.addr : sel_addr;
    res.remapped = (best_ch != base);
  end

endmodule

>>> hw/rtl/load_aware_channel_remap.sv
// Load-aware channel remapper. Each accepted word carries a request address
// and the pending counts of four channels; one result word comes back with
// the channel to use, the address to send downstream (XOR-remapped when the
// channel was switched) and a remap flag. The block is a two-register
// pipeline: the request is captured in an input register, the mapping is
// computed in one pass of compare and xor logic, and the result sits in an
// output register. It takes a word every cycle while the output side is not
// stalled; each result is held in the output register until it is taken.
// Registers are written through the cfg_ port and must only be changed while
// no request is in flight.
module load_aware_channel_remap
  import lacr_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,

  input  logic                 cfg_wr_en,
  input  logic [REG_IDX_W-1:0] cfg_index,
  input  logic [ADDR_W-1:0]    cfg_wdata,

  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [ADDR_W-1:0]    in_request_address,
  input  logic [CNT_W-1:0]     in_pending_count_0,
  input  logic [CNT_W-1:0]     in_pending_count_1,
  input  logic [CNT_W-1:0]     in_pending_count_2,
  input  logic [CNT_W-1:0]     in_pending_count_3,

  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [CH_W-1:0]      out_chosen_channel,
  output logic [ADDR_W-1:0]    out_mapped_address,
  output logic                 out_was_remapped
);

  cfg_t cfg_r;
  req_t req_r;
  logic req_valid_r;
  res_t res_r;
  logic res_valid_r;
  res_t res_nxt;
  logic res_free;
  logic advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode         <= MODE_BASE;
      cfg_r.xor_mask     <= '0;
      cfg_r.threshold    <= '0;
      cfg_r.search_width <= SW_W'(1);
      cfg_r.margin       <= '0;
      cfg_r.addr_shift   <= SHIFT_W'(6);
      cfg_r.ch_pos       <= '0;
      cfg_r.ch_bits      <= 2'd2;
    end else if (cfg_wr_en) begin
      unique case (reg_idx_t'(cfg_index))
        REG_MODE:       cfg_r.mode         <= cfg_wdata[1:0];
        REG_XOR_MASK:   cfg_r.xor_mask     <= cfg_wdata;
        REG_THRESHOLD:  cfg_r.threshold    <= cfg_wdata[CNT_W-1:0];
        REG_SEARCH_W:   cfg_r.search_width <= cfg_wdata[SW_W-1:0];
        REG_MARGIN:     cfg_r.margin       <= cfg_wdata[CNT_W-1:0];
        REG_ADDR_SHIFT: cfg_r.addr_shift   <= cfg_wdata[SHIFT_W-1:0];
        REG_CH_POS:     cfg_r.ch_pos       <= cfg_wdata[SHIFT_W-1:0];
        REG_CH_BITS:    cfg_r.ch_bits      <= cfg_wdata[1:0];
        default: ;
      endcase
    end
  end

  // The input stage moves on whenever the output register is empty or is
  // being drained this cycle.
  assign res_free = !res_valid_r || out_ready;
  assign advance  = req_valid_r && res_free;
  assign in_ready = !req_valid_r || res_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_valid_r <= 1'b0;
    end else if (in_ready) begin
      req_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req_r.addr     <= in_request_address;
      req_r.count[0] <= in_pending_count_0;
      req_r.count[1] <= in_pending_count_1;
      req_r.count[2] <= in_pending_count_2;
      req_r.count[3] <= in_pending_count_3;
    end
  end

  lacr_core u_core (
    .cfg (cfg_r),
    .req (req_r),
    .res (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r <= 1'b0;
    end else if (res_free) begin
      res_valid_r <= req_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid          = res_valid_r;
  assign out_chosen_channel = res_r.ch;
  assign out_mapped_address = res_r.addr;
  assign out_was_remapped   = res_r.remapped;

endmodule
